// ----- rtl/rtp_h264_fragment_reassembler_assert.svh -----
// Assertion macros for the RTP H.264 fragment reassembler.
`ifndef RTP_H264_FRAGMENT_REASSEMBLER_ASSERT_SVH
`define RTP_H264_FRAGMENT_REASSEMBLER_ASSERT_SVH

`ifndef SYNTHESIS

`define RTPFR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rtpfr assertion failed");

`define RTPFR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rtpfr forbidden condition");

`else

`define RTPFR_ASSERT(lbl, clk, rst_n, prop)
`define RTPFR_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- rtl/rtpfr_pkg.sv -----
`timescale 1ns / 1ps

package rtpfr_pkg;

    localparam int NALU_BUFFER_BYTES  = 4096;
    localparam int MAX_DATAGRAM_BYTES = 2048;

    localparam int POS_W    = $clog2(MAX_DATAGRAM_BYTES + 1);
    localparam int LEN_W    = $clog2(NALU_BUFFER_BYTES + 1);
    localparam int OFFSET_W = 12;
    localparam int NALU_LEN_OUT_W = 13;

    localparam int RTP_HDR_LEN = 12;

    localparam logic [4:0] IDR_TYPE  = 5'd5;
    localparam logic [4:0] FU_A_TYPE = 5'd28;
    localparam logic [7:0] NRI_MASK  = 8'hE0;
    localparam logic [7:0] PACK_START_CODE = 8'hBA;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int COUNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam int TDATA_W = 136;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [3:0] {
        EV_SHORT          = 4'd0,
        EV_PS_PACK        = 4'd1,
        EV_RAW_IDR        = 4'd2,
        EV_FRAG_TAKEN     = 4'd3,
        EV_NALU_COMPLETE  = 4'd4,
        EV_NO_START       = 4'd5,
        EV_STREAM_CHANGED = 4'd6,
        EV_SEQ_GAP        = 4'd7,
        EV_UNKNOWN        = 4'd8
    } event_code_t;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_EVENT = 1'b1
    } result_kind_t;

    typedef struct packed {
        result_kind_t              kind;
        event_code_t               code;
        logic [OFFSET_W-1:0]       write_offset;
        logic [7:0]                write_value;
        logic [NALU_LEN_OUT_W-1:0] nalu_length;
        logic [7:0]                nalu_header_byte;
        logic [31:0]               timestamp;
        logic [31:0]               ssrc;
        logic [15:0]               sequence_num;
        logic [6:0]                rtp_pt;
        logic                      marker;
        logic                      last_in_run;
    } result_t;

endpackage

// ----- rtl/rtp_h264_fragment_reassembler.sv -----
`timescale 1ns / 1ps
// Results are registered into a four-entry result queue when their byte is accepted.
// Throughput: one byte per cycle; a byte yields up to two results, drained one per cycle
//   while m_tready is high; the queue holds off input when under two free slots.
// Reset: synchronous, active low; clears parse state, reassembly context and queue.
`include "rtp_h264_fragment_reassembler_assert.svh"

module rtp_h264_fragment_reassembler (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [3:0] event_code, [15:4] write_offset, [23:16] write_value,
    // [36:24] nalu_length, [44:37] nalu_header_byte, [76:45] rtp_timestamp,
    // [108:77] rtp_ssrc, [124:109] rtp_sequence, [131:125] rtp_payload_type,
    // [132] rtp_marker, [135:133] zero
    output logic [rtpfr_pkg::TDATA_W-1:0] m_tdata,
    output logic         m_tuser,   // [0] result_kind
    output logic         m_tlast    // last_in_run
);

    rtpfr_pkg::pos_t          pos_reg, pos_next;
    logic [15:0]              hdr_seq_reg, hdr_seq_next;
    logic [31:0]              hdr_ts_reg, hdr_ts_next;
    logic [31:0]              hdr_ssrc_reg, hdr_ssrc_next;
    logic [7:0]               hdr_tm_reg, hdr_tm_next;
    logic [7:0]               first_pl_reg, first_pl_next;
    logic                     pack_match_reg, pack_match_next;
    rtpfr_pkg::event_code_t   verdict_reg, verdict_next;
    logic                     end_seen_reg, end_seen_next;
    logic                     ctx_active_reg, ctx_active_next;
    logic [31:0]              ctx_ts_reg, ctx_ts_next;
    logic [31:0]              ctx_ssrc_reg, ctx_ssrc_next;
    logic [15:0]              ctx_exp_seq_reg, ctx_exp_seq_next;
    logic [7:0]               ctx_hdr_reg, ctx_hdr_next;
    rtpfr_pkg::len_t          ctx_len_reg, ctx_len_next;

    rtpfr_pkg::result_t       fifo_mem [rtpfr_pkg::FIFO_DEPTH];
    logic [rtpfr_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [rtpfr_pkg::COUNT_W-1:0] fifo_count_reg, fifo_count_next;

    rtpfr_pkg::result_t       wr_res, ev_res, res0, res1;
    logic                     wr_emit;
    logic [1:0]               res_count;
    logic                     accept, pop;
    logic [4:0]               fu_type;
    logic [7:0]               fu_hdr;
    rtpfr_pkg::pos_t          p;
    logic [7:0]               b;

    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = fifo_count_reg <= rtpfr_pkg::COUNT_W'(rtpfr_pkg::FIFO_DEPTH - 2);
    assign m_tvalid = fifo_count_reg != '0;
    assign p        = pos_reg;
    assign b        = s_tdata;

    always_comb begin
        pos_next         = pos_reg;
        hdr_seq_next     = hdr_seq_reg;
        hdr_ts_next      = hdr_ts_reg;
        hdr_ssrc_next    = hdr_ssrc_reg;
        hdr_tm_next      = hdr_tm_reg;
        first_pl_next    = first_pl_reg;
        pack_match_next  = pack_match_reg;
        verdict_next     = verdict_reg;
        end_seen_next    = end_seen_reg;
        ctx_active_next  = ctx_active_reg;
        ctx_ts_next      = ctx_ts_reg;
        ctx_ssrc_next    = ctx_ssrc_reg;
        ctx_exp_seq_next = ctx_exp_seq_reg;
        ctx_hdr_next     = ctx_hdr_reg;
        ctx_len_next     = ctx_len_reg;
        wr_emit          = 1'b0;
        wr_res           = '0;
        ev_res           = '0;
        res0             = '0;
        res1             = '0;
        res_count        = 2'd0;
        fu_type          = first_pl_reg[4:0];
        fu_hdr           = (first_pl_reg & rtpfr_pkg::NRI_MASK) | {3'b000, b[4:0]};

        if (p == '0) begin
            hdr_seq_next    = '0;
            hdr_ts_next     = '0;
            hdr_ssrc_next   = '0;
            hdr_tm_next     = '0;
            first_pl_next   = '0;
            pack_match_next = 1'b0;
            verdict_next    = rtpfr_pkg::EV_UNKNOWN;
            end_seen_next   = 1'b0;
        end

        if (p < rtpfr_pkg::pos_t'(rtpfr_pkg::MAX_DATAGRAM_BYTES)) begin
            if (p == rtpfr_pkg::pos_t'(1)) begin
                hdr_tm_next = b;
            end else if (p == rtpfr_pkg::pos_t'(2) || p == rtpfr_pkg::pos_t'(3)) begin
                hdr_seq_next = {hdr_seq_next[7:0], b};
            end else if (p >= rtpfr_pkg::pos_t'(4) && p <= rtpfr_pkg::pos_t'(7)) begin
                hdr_ts_next = {hdr_ts_next[23:0], b};
            end else if (p >= rtpfr_pkg::pos_t'(8) && p <= rtpfr_pkg::pos_t'(11)) begin
                hdr_ssrc_next = {hdr_ssrc_next[23:0], b};
            end else if (p == rtpfr_pkg::pos_t'(12)) begin
                first_pl_next   = b;
                pack_match_next = (b == 8'h00);
                if (b[4:0] == rtpfr_pkg::IDR_TYPE) begin
                    verdict_next = rtpfr_pkg::EV_RAW_IDR;
                end
            end else if (p == rtpfr_pkg::pos_t'(13)) begin
                pack_match_next = pack_match_next && (b == 8'h00);
                if (fu_type == rtpfr_pkg::FU_A_TYPE) begin
                    end_seen_next = b[6];
                    if (b[7]) begin
                        ctx_active_next  = 1'b1;
                        ctx_ts_next      = hdr_ts_next;
                        ctx_ssrc_next    = hdr_ssrc_next;
                        ctx_exp_seq_next = hdr_seq_next + 16'd1;
                        ctx_hdr_next     = fu_hdr;
                        ctx_len_next     = '0;
                        verdict_next     = rtpfr_pkg::EV_FRAG_TAKEN;
                    end else if (!ctx_active_next) begin
                        verdict_next = rtpfr_pkg::EV_NO_START;
                    end else if (ctx_ts_next != hdr_ts_next
                                 || ctx_ssrc_next != hdr_ssrc_next) begin
                        ctx_active_next  = 1'b0;
                        ctx_ts_next      = '0;
                        ctx_ssrc_next    = '0;
                        ctx_exp_seq_next = '0;
                        ctx_hdr_next     = '0;
                        ctx_len_next     = '0;
                        verdict_next     = rtpfr_pkg::EV_STREAM_CHANGED;
                    end else if (hdr_seq_next != ctx_exp_seq_next) begin
                        ctx_active_next  = 1'b0;
                        ctx_ts_next      = '0;
                        ctx_ssrc_next    = '0;
                        ctx_exp_seq_next = '0;
                        ctx_hdr_next     = '0;
                        ctx_len_next     = '0;
                        verdict_next     = rtpfr_pkg::EV_SEQ_GAP;
                    end else begin
                        ctx_exp_seq_next = hdr_seq_next + 16'd1;
                        verdict_next     = rtpfr_pkg::EV_FRAG_TAKEN;
                    end
                    if (verdict_next == rtpfr_pkg::EV_FRAG_TAKEN && ctx_len_next == '0) begin
                        wr_emit             = 1'b1;
                        wr_res.write_value  = ctx_hdr_next;
                    end
                end
            end else if (p != '0) begin
                if (p == rtpfr_pkg::pos_t'(14)) begin
                    pack_match_next = pack_match_next && (b == 8'h01);
                end else if (p == rtpfr_pkg::pos_t'(15) && pack_match_next
                             && b == rtpfr_pkg::PACK_START_CODE) begin
                    verdict_next = rtpfr_pkg::EV_PS_PACK;
                end
                if (verdict_next == rtpfr_pkg::EV_FRAG_TAKEN
                    && ctx_len_next < rtpfr_pkg::len_t'(rtpfr_pkg::NALU_BUFFER_BYTES)) begin
                    wr_emit            = 1'b1;
                    wr_res.write_value = b;
                end
            end
            if (wr_emit) begin
                wr_res.kind             = rtpfr_pkg::KIND_WRITE;
                wr_res.code             = rtpfr_pkg::EV_SHORT;
                wr_res.write_offset     = ctx_len_next[rtpfr_pkg::OFFSET_W-1:0];
                wr_res.nalu_header_byte = ctx_hdr_next;
                wr_res.timestamp        = hdr_ts_next;
                wr_res.ssrc             = hdr_ssrc_next;
                wr_res.sequence_num     = hdr_seq_next;
                wr_res.rtp_pt           = hdr_tm_next[6:0];
                wr_res.marker           = hdr_tm_next[7];
                if (ctx_len_next < rtpfr_pkg::len_t'(rtpfr_pkg::NALU_BUFFER_BYTES)) begin
                    ctx_len_next = ctx_len_next + rtpfr_pkg::len_t'(1);
                end
            end
            pos_next = p + rtpfr_pkg::pos_t'(1);
        end

        if (s_tlast) begin
            ev_res.kind = rtpfr_pkg::KIND_EVENT;
            if (p < rtpfr_pkg::pos_t'(rtpfr_pkg::RTP_HDR_LEN - 1)) begin
                ev_res.code = rtpfr_pkg::EV_SHORT;
            end else begin
                ev_res.timestamp    = hdr_ts_next;
                ev_res.ssrc         = hdr_ssrc_next;
                ev_res.sequence_num = hdr_seq_next;
                ev_res.rtp_pt       = hdr_tm_next[6:0];
                ev_res.marker       = hdr_tm_next[7];
                if (verdict_next == rtpfr_pkg::EV_FRAG_TAKEN && end_seen_next) begin
                    ev_res.code             = rtpfr_pkg::EV_NALU_COMPLETE;
                    ev_res.nalu_length      = rtpfr_pkg::NALU_LEN_OUT_W'(ctx_len_next);
                    ev_res.nalu_header_byte = ctx_hdr_next;
                    ev_res.timestamp        = ctx_ts_next;
                    ev_res.ssrc             = ctx_ssrc_next;
                    ctx_active_next  = 1'b0;
                    ctx_ts_next      = '0;
                    ctx_ssrc_next    = '0;
                    ctx_exp_seq_next = '0;
                    ctx_hdr_next     = '0;
                    ctx_len_next     = '0;
                end else if (verdict_next == rtpfr_pkg::EV_FRAG_TAKEN) begin
                    ev_res.code             = rtpfr_pkg::EV_FRAG_TAKEN;
                    ev_res.nalu_header_byte = ctx_hdr_next;
                end else begin
                    ev_res.code = verdict_next;
                end
            end
            pos_next = '0;
        end

        if (wr_emit && s_tlast) begin
            res0             = wr_res;
            res1             = ev_res;
            res1.last_in_run = 1'b1;
            res_count        = 2'd2;
        end else if (wr_emit) begin
            res0             = wr_res;
            res0.last_in_run = 1'b1;
            res_count        = 2'd1;
        end else if (s_tlast) begin
            res0             = ev_res;
            res0.last_in_run = 1'b1;
            res_count        = 2'd1;
        end
    end

    always_comb begin
        fifo_count_next = fifo_count_reg;
        if (accept) begin
            fifo_count_next = fifo_count_next + rtpfr_pkg::COUNT_W'(res_count);
        end
        if (pop) begin
            fifo_count_next = fifo_count_next - rtpfr_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            hdr_seq_reg     <= '0;
            hdr_ts_reg      <= '0;
            hdr_ssrc_reg    <= '0;
            hdr_tm_reg      <= '0;
            first_pl_reg    <= '0;
            pack_match_reg  <= 1'b0;
            verdict_reg     <= rtpfr_pkg::EV_SHORT;
            end_seen_reg    <= 1'b0;
            ctx_active_reg  <= 1'b0;
            ctx_ts_reg      <= '0;
            ctx_ssrc_reg    <= '0;
            ctx_exp_seq_reg <= '0;
            ctx_hdr_reg     <= '0;
            ctx_len_reg     <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            fifo_count_reg  <= '0;
        end else begin
            if (accept) begin
                pos_reg         <= pos_next;
                hdr_seq_reg     <= hdr_seq_next;
                hdr_ts_reg      <= hdr_ts_next;
                hdr_ssrc_reg    <= hdr_ssrc_next;
                hdr_tm_reg      <= hdr_tm_next;
                first_pl_reg    <= first_pl_next;
                pack_match_reg  <= pack_match_next;
                verdict_reg     <= verdict_next;
                end_seen_reg    <= end_seen_next;
                ctx_active_reg  <= ctx_active_next;
                ctx_ts_reg      <= ctx_ts_next;
                ctx_ssrc_reg    <= ctx_ssrc_next;
                ctx_exp_seq_reg <= ctx_exp_seq_next;
                ctx_hdr_reg     <= ctx_hdr_next;
                ctx_len_reg     <= ctx_len_next;
                wr_ptr_reg      <= wr_ptr_reg + rtpfr_pkg::FIFO_AW'(res_count);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + rtpfr_pkg::FIFO_AW'(1);
            end
            fifo_count_reg <= fifo_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_count != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (accept && res_count == 2'd2) begin
            fifo_mem[wr_ptr_reg + rtpfr_pkg::FIFO_AW'(1)] <= res1;
        end
    end

    rtpfr_pkg::result_t head;
    assign head = fifo_mem[rd_ptr_reg];

    assign m_tdata = {3'b000, head.marker, head.rtp_pt, head.sequence_num,
                      head.ssrc, head.timestamp, head.nalu_header_byte,
                      head.nalu_length, head.write_value, head.write_offset,
                      head.code};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_in_run;

    `RTPFR_ASSERT_NEVER(a_fifo_bound, aclk, aresetn,
        fifo_count_reg > rtpfr_pkg::COUNT_W'(rtpfr_pkg::FIFO_DEPTH))
    `RTPFR_ASSERT(a_double_push, aclk, aresetn,
        (accept && res_count == 2'd2 && !pop)
            |=> (fifo_count_reg == $past(fifo_count_reg) + rtpfr_pkg::COUNT_W'(2)))
    `RTPFR_ASSERT(a_idle_ctx_empty, aclk, aresetn,
        !ctx_active_reg |-> (ctx_len_reg == '0 && ctx_hdr_reg == '0))
    `RTPFR_ASSERT_NEVER(a_len_bound, aclk, aresetn,
        ctx_len_reg > rtpfr_pkg::len_t'(rtpfr_pkg::NALU_BUFFER_BYTES))
    `RTPFR_ASSERT_NEVER(a_pos_bound, aclk, aresetn,
        pos_reg > rtpfr_pkg::pos_t'(rtpfr_pkg::MAX_DATAGRAM_BYTES))

endmodule

// ----- bench/tb_rtp_h264_fragment_reassembler.sv -----
`timescale 1ns / 1ps

module tb_rtp_h264_fragment_reassembler;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 16;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } wire_byte_t;

    typedef enum int {
        DAMAGE_NONE,
        DAMAGE_GAP,
        DAMAGE_TIMESTAMP,
        DAMAGE_SSRC,
        DAMAGE_NO_START,
        DAMAGE_RESTART,
        DAMAGE_NOISE,
        DAMAGE_NO_END,
        DAMAGE_EARLY_END
    } damage_t;

    typedef enum int {
        NOISE_SHORT,
        NOISE_HEADER_ONLY,
        NOISE_IDR,
        NOISE_PACK,
        NOISE_NEAR_PACK,
        NOISE_UNKNOWN,
        NOISE_TINY_FU
    } noise_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = 8'h00;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [rtpfr_pkg::TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    rtp_h264_fragment_reassembler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    wire_byte_t  datagram_bytes[$];
    logic [7:0]  dg[$];
    rtpfr_pkg::result_t pending_results[$];
    int          errors = 0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          idle_odds = 8;
    int          cycle_count = 0;
    int          stall_cycles = 0;
    logic [31:0] stream_ssrc;
    wire_byte_t  next_byte;
    rtpfr_pkg::result_t got;
    rtpfr_pkg::result_t want;

    // depacketizer state
    int          pos;
    logic [15:0] h_seq;
    logic [31:0] h_ts;
    logic [31:0] h_ssrc;
    logic [7:0]  h_type_marker;
    logic [7:0]  first_payload;
    bit          prefix_ok;
    rtpfr_pkg::event_code_t verdict;
    bit          end_seen;
    bit          ctx_open;
    logic [31:0] ctx_ts;
    logic [31:0] ctx_ssrc;
    logic [15:0] ctx_next_seq;
    logic [7:0]  ctx_hdr;
    int          ctx_len;

    function automatic rtpfr_pkg::result_t make_result(rtpfr_pkg::result_kind_t kind,
                                                       rtpfr_pkg::event_code_t code, int off,
                                                       logic [7:0] val, int len,
                                                       logic [7:0] hdr, logic [31:0] ts,
                                                       logic [31:0] ssrc, bit hv);
        rtpfr_pkg::result_t r;
        r.kind             = kind;
        r.code             = code;
        r.write_offset     = off[11:0];
        r.write_value      = val;
        r.nalu_length      = len[12:0];
        r.nalu_header_byte = hdr;
        r.timestamp        = hv ? ts : 32'h0;
        r.ssrc             = hv ? ssrc : 32'h0;
        r.sequence_num     = hv ? h_seq : 16'h0;
        r.rtp_pt           = hv ? h_type_marker[6:0] : 7'h0;
        r.marker           = hv ? h_type_marker[7] : 1'b0;
        r.last_in_run      = 1'b0;
        return r;
    endfunction

    function automatic rtpfr_pkg::result_t nalu_write(logic [7:0] val);
        rtpfr_pkg::result_t r;
        r = make_result(rtpfr_pkg::KIND_WRITE, rtpfr_pkg::EV_SHORT, ctx_len, val, 0, ctx_hdr,
                        h_ts, h_ssrc, 1'b1);
        if (ctx_len < rtpfr_pkg::NALU_BUFFER_BYTES) ctx_len++;
        return r;
    endfunction

    function automatic void drop_context();
        ctx_open     = 1'b0;
        ctx_ts       = '0;
        ctx_ssrc     = '0;
        ctx_next_seq = '0;
        ctx_hdr      = '0;
        ctx_len      = 0;
    endfunction

    function automatic void take_fu_header(logic [7:0] fu);
        end_seen = fu[6];
        if (fu[7]) begin
            ctx_open     = 1'b1;
            ctx_ts       = h_ts;
            ctx_ssrc     = h_ssrc;
            ctx_next_seq = h_seq + 16'd1;
            ctx_hdr      = (first_payload & rtpfr_pkg::NRI_MASK) | {3'b000, fu[4:0]};
            ctx_len      = 0;
            verdict      = rtpfr_pkg::EV_FRAG_TAKEN;
        end else if (!ctx_open) begin
            verdict = rtpfr_pkg::EV_NO_START;
        end else if (ctx_ts != h_ts || ctx_ssrc != h_ssrc) begin
            drop_context();
            verdict = rtpfr_pkg::EV_STREAM_CHANGED;
        end else if (h_seq != ctx_next_seq) begin
            drop_context();
            verdict = rtpfr_pkg::EV_SEQ_GAP;
        end else begin
            ctx_next_seq = h_seq + 16'd1;
            verdict      = rtpfr_pkg::EV_FRAG_TAKEN;
        end
    endfunction

    function automatic void depacketize_byte(logic [7:0] b, logic last);
        rtpfr_pkg::result_t run[$];
        int      p;
        int      size;
        p = pos;
        if (p == 0) begin
            h_seq         = '0;
            h_ts          = '0;
            h_ssrc        = '0;
            h_type_marker = '0;
            first_payload = '0;
            prefix_ok     = 1'b0;
            verdict       = rtpfr_pkg::EV_UNKNOWN;
            end_seen      = 1'b0;
        end
        if (p < rtpfr_pkg::MAX_DATAGRAM_BYTES) begin
            if (p == 1) begin
                h_type_marker = b;
            end else if (p == 2 || p == 3) begin
                h_seq = {h_seq[7:0], b};
            end else if (p >= 4 && p <= 7) begin
                h_ts = {h_ts[23:0], b};
            end else if (p >= 8 && p <= 11) begin
                h_ssrc = {h_ssrc[23:0], b};
            end else if (p == rtpfr_pkg::RTP_HDR_LEN) begin
                first_payload = b;
                prefix_ok = (b == 8'h00);
                if (b[4:0] == rtpfr_pkg::IDR_TYPE) verdict = rtpfr_pkg::EV_RAW_IDR;
            end else if (p == rtpfr_pkg::RTP_HDR_LEN + 1) begin
                prefix_ok = prefix_ok && (b == 8'h00);
                if (first_payload[4:0] == rtpfr_pkg::FU_A_TYPE) begin
                    take_fu_header(b);
                    if (verdict == rtpfr_pkg::EV_FRAG_TAKEN && ctx_len == 0)
                        run.push_back(nalu_write(ctx_hdr));
                end
            end else begin
                if (p == rtpfr_pkg::RTP_HDR_LEN + 2)
                    prefix_ok = prefix_ok && (b == 8'h01);
                else if (p == rtpfr_pkg::RTP_HDR_LEN + 3 && prefix_ok
                         && b == rtpfr_pkg::PACK_START_CODE)
                    verdict = rtpfr_pkg::EV_PS_PACK;
                if (verdict == rtpfr_pkg::EV_FRAG_TAKEN
                    && ctx_len < rtpfr_pkg::NALU_BUFFER_BYTES)
                    run.push_back(nalu_write(b));
            end
            pos = p + 1;
        end
        if (last) begin
            size = (p + 1 > rtpfr_pkg::MAX_DATAGRAM_BYTES) ? rtpfr_pkg::MAX_DATAGRAM_BYTES
                                                           : p + 1;
            if (size < rtpfr_pkg::RTP_HDR_LEN) begin
                run.push_back(make_result(rtpfr_pkg::KIND_EVENT, rtpfr_pkg::EV_SHORT, 0,
                                          8'h00, 0, 8'h00, 32'h0, 32'h0, 1'b0));
            end else if (verdict == rtpfr_pkg::EV_FRAG_TAKEN && end_seen) begin
                run.push_back(make_result(rtpfr_pkg::KIND_EVENT, rtpfr_pkg::EV_NALU_COMPLETE,
                                          0, 8'h00, ctx_len, ctx_hdr, ctx_ts, ctx_ssrc,
                                          1'b1));
                drop_context();
            end else if (verdict == rtpfr_pkg::EV_FRAG_TAKEN) begin
                run.push_back(make_result(rtpfr_pkg::KIND_EVENT, rtpfr_pkg::EV_FRAG_TAKEN, 0,
                                          8'h00, 0, ctx_hdr, h_ts, h_ssrc, 1'b1));
            end else begin
                run.push_back(make_result(rtpfr_pkg::KIND_EVENT, verdict, 0, 8'h00, 0, 8'h00,
                                          h_ts, h_ssrc, 1'b1));
            end
            pos = 0;
        end
        if (run.size() > 0) run[run.size() - 1].last_in_run = 1'b1;
        foreach (run[i]) pending_results.push_back(run[i]);
    endfunction

    function automatic string show(rtpfr_pkg::result_t r);
        return {$sformatf("kind=%0d code=%0d off=%0d val=%02h len=%0d hdr=%02h ",
                          r.kind, r.code, r.write_offset, r.write_value, r.nalu_length,
                          r.nalu_header_byte),
                $sformatf("ts=%08h ssrc=%08h seq=%04h pt=%0d m=%0d last=%0d",
                          r.timestamp, r.ssrc, r.sequence_num, r.rtp_pt, r.marker,
                          r.last_in_run)};
    endfunction

    function automatic bit quiet_tail();
        return datagram_bytes.size() < 300;
    endfunction

    task automatic put_random(input int n);
        repeat (n) dg.push_back(8'($urandom));
    endtask

    task automatic put_header(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [15:0] seq, input logic [31:0] ts,
                              input logic [31:0] ssrc);
        dg = {};
        dg.push_back(b0);
        dg.push_back(b1);
        dg.push_back(seq[15:8]);
        dg.push_back(seq[7:0]);
        for (int i = 3; i >= 0; i--) dg.push_back(ts[8*i +: 8]);
        for (int i = 3; i >= 0; i--) dg.push_back(ssrc[8*i +: 8]);
    endtask

    task automatic flush_datagram();
        wire_byte_t w;
        foreach (dg[i]) begin
            w.data = dg[i];
            w.last = (i == dg.size() - 1);
            datagram_bytes.push_back(w);
        end
        dg = {};
    endtask

    task automatic send_fu(input logic [31:0] ts, input logic [31:0] ssrc,
                           input logic [15:0] seq, input logic [7:0] fu, input int n);
        logic [2:0] nri;
        nri = 3'($urandom);
        put_header(8'($urandom), 8'($urandom), seq, ts, ssrc);
        dg.push_back({nri, rtpfr_pkg::FU_A_TYPE});
        dg.push_back(fu);
        put_random(n);
        flush_datagram();
    endtask

    task automatic send_noise(input noise_t kind);
        logic [2:0] top;
        top = 3'($urandom);
        if (kind == NOISE_SHORT) begin
            dg = {};
            put_random($urandom_range(1, rtpfr_pkg::RTP_HDR_LEN - 1));
            flush_datagram();
            return;
        end
        put_random(rtpfr_pkg::RTP_HDR_LEN);
        case (kind)
            NOISE_IDR: begin
                dg.push_back({top, rtpfr_pkg::IDR_TYPE});
                put_random($urandom_range(0, 20));
            end
            NOISE_PACK: begin
                dg.push_back(8'h00);
                dg.push_back(8'h00);
                dg.push_back(8'h01);
                dg.push_back(rtpfr_pkg::PACK_START_CODE);
                put_random($urandom_range(0, 12));
            end
            NOISE_NEAR_PACK: begin
                dg.push_back(8'h00);
                dg.push_back(8'($urandom_range(0, 1)));
                dg.push_back(8'($urandom_range(0, 2)));
                put_random($urandom_range(0, 6));
            end
            NOISE_UNKNOWN: put_random($urandom_range(1, 24));
            NOISE_TINY_FU: dg.push_back({top, rtpfr_pkg::FU_A_TYPE});
            default: ;
        endcase
        flush_datagram();
    endtask

    task automatic send_nalu(input int frags, input int max_len, input damage_t damage);
        logic [31:0] ts;
        logic [31:0] ssrc;
        logic [15:0] seq;
        logic [7:0]  fu;
        int          hit;
        ts   = $urandom;
        ssrc = stream_ssrc;
        seq  = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                           : 16'($urandom);
        hit  = $urandom_range(0, frags - 1);
        for (int i = 0; i < frags; i++) begin
            fu = {i == 0, i == frags - 1, 1'($urandom), 5'($urandom)};
            if (i == hit) begin
                case (damage)
                    DAMAGE_GAP:       seq = seq + 16'($urandom_range(1, 200));
                    DAMAGE_RESTART:   fu[7] = 1'b1;
                    DAMAGE_EARLY_END: fu[6] = 1'b1;
                    DAMAGE_NOISE:     send_noise(noise_t'($urandom_range(0, 6)));
                    default: ;
                endcase
            end
            if (damage == DAMAGE_NO_START && i == 0 && frags > 1) begin
                seq = seq + 16'd1;
                continue;
            end
            if (damage == DAMAGE_NO_END && i == frags - 1 && frags > 1) break;
            if (i == hit && damage == DAMAGE_TIMESTAMP)
                send_fu(ts ^ (32'd1 << $urandom_range(0, 31)), ssrc, seq, fu,
                        $urandom_range(0, max_len));
            else if (i == hit && damage == DAMAGE_SSRC)
                send_fu(ts, ssrc ^ (32'd1 << $urandom_range(0, 31)), seq, fu,
                        $urandom_range(0, max_len));
            else
                send_fu(ts, ssrc, seq, fu, $urandom_range(0, max_len));
            seq = seq + 16'd1;
        end
    endtask

    task automatic build_stimulus();
        int target;
        // short datagrams
        put_random(1);
        flush_datagram();
        put_random(rtpfr_pkg::RTP_HDR_LEN - 1);
        flush_datagram();
        // header only, all-ones fields
        put_header(8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        flush_datagram();
        // FU-A indicator with no FU header
        put_header(8'h80, 8'h60, 16'h0000, 32'h0, 32'h0);
        dg.push_back({3'b011, rtpfr_pkg::FU_A_TYPE});
        flush_datagram();
        // raw IDR, PS pack, unknown type
        put_header(8'h80, 8'hE0, 16'h0001, 32'h0000_0001, 32'h0000_0002);
        dg.push_back({3'b011, rtpfr_pkg::IDR_TYPE});
        put_random(4);
        flush_datagram();
        put_header(8'h80, 8'h60, 16'h0002, 32'h0000_0003, 32'h0000_0002);
        dg.push_back(8'h00);
        dg.push_back(8'h00);
        dg.push_back(8'h01);
        dg.push_back(rtpfr_pkg::PACK_START_CODE);
        put_random(3);
        flush_datagram();
        put_header(8'h80, 8'h60, 16'h0003, 32'h0000_0004, 32'h0000_0002);
        dg.push_back(8'h41);
        put_random(2);
        flush_datagram();
        // continuation with no open context
        send_fu(32'd100, 32'd7, 16'd10, 8'h05, 3);
        // single-fragment NALU
        send_fu(32'd101, 32'd7, 16'd20, 8'hC5, 2);
        // sequence wrap across a NALU
        send_fu(32'd102, 32'd7, 16'hFFFE, 8'h81, 2);
        send_fu(32'd102, 32'd7, 16'hFFFF, 8'h01, 2);
        send_fu(32'd102, 32'd7, 16'h0000, 8'h41, 2);
        // sequence gap
        send_fu(32'd103, 32'd7, 16'd30, 8'h81, 1);
        send_fu(32'd103, 32'd7, 16'd32, 8'h01, 1);
        // timestamp change, SSRC change
        send_fu(32'd104, 32'd7, 16'd40, 8'h81, 1);
        send_fu(32'd105, 32'd7, 16'd41, 8'h01, 1);
        send_fu(32'd106, 32'd7, 16'd42, 8'h81, 1);
        send_fu(32'd106, 32'd8, 16'd43, 8'h41, 1);
        // new start replaces open context
        send_fu(32'd107, 32'd7, 16'd50, 8'h81, 2);
        send_fu(32'd108, 32'd9, 16'd60, 8'h9F, 2);
        send_fu(32'd108, 32'd9, 16'd61, 8'h5F, 2);

        target = 1400;
        while (datagram_bytes.size() < target) begin
            if ($urandom_range(0, 9) == 0) stream_ssrc = $urandom;
            if ($urandom_range(0, 4) == 0)
                send_noise(noise_t'($urandom_range(0, 6)));
            else
                send_nalu($urandom_range(1, 5),
                          ($urandom_range(0, 15) == 0) ? 300 : 24,
                          ($urandom_range(0, 9) < 6) ? DAMAGE_NONE
                                                      : damage_t'($urandom_range(1, 8)));
        end
    endtask

    initial begin
        pos = 0;
        h_seq = '0;
        h_ts = '0;
        h_ssrc = '0;
        h_type_marker = '0;
        first_payload = '0;
        prefix_ok = 1'b0;
        verdict = rtpfr_pkg::EV_SHORT;
        end_seen = 1'b0;
        drop_context();
        stream_ssrc = $urandom;
        build_stimulus();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        while (datagram_bytes.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb_rtp_h264_fragment_reassembler: PASS");
        else
            $display("tb_rtp_h264_fragment_reassembler: FAIL");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
            src_gap  = 0;
        end else begin
            if (s_tvalid && s_tready) depacketize_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (datagram_bytes.size() > 0) begin
                    next_byte = datagram_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_byte.data;
                    s_tlast  <= next_byte.last;
                    if (!quiet_tail() && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                        src_gap = $urandom_range(1, 12);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            cycle_count++;
            if (cycle_count % 256 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_odds = 0;
                    1: idle_odds = 4;
                    default: idle_odds = 20;
                endcase
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (!quiet_tail() && idle_odds != 0
                         && $urandom_range(1, idle_odds) == 1) begin
                sink_gap = $urandom_range(0, 11);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.kind             = rtpfr_pkg::result_kind_t'(m_tuser);
            got.code             = rtpfr_pkg::event_code_t'(m_tdata[3:0]);
            got.write_offset     = m_tdata[15:4];
            got.write_value      = m_tdata[23:16];
            got.nalu_length      = m_tdata[36:24];
            got.nalu_header_byte = m_tdata[44:37];
            got.timestamp        = m_tdata[76:45];
            got.ssrc             = m_tdata[108:77];
            got.sequence_num     = m_tdata[124:109];
            got.rtp_pt           = m_tdata[131:125];
            got.marker           = m_tdata[132];
            got.last_in_run      = m_tlast;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transaction: %s", show(got));
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_tdata[135:133] !== 3'b000) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch (pad=%b)\n  expected %s\n  actual   %s",
                                 m_tdata[135:133], show(want), show(got));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_rtp_h264_fragment_reassembler: FAIL");
                $finish;
            end
        end
    end

endmodule
